// ===== rtl/lik_pkg.sv =====
// lik_pkg: shared types, constants and helper functions of the leg inverse kinematics block
// used by lik_sqrt_cell, lik_cordic_cell and leg_inverse_kinematics_3dof
// no dependencies
package lik_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = 5;
    localparam int SQ_STEPS      = 30;
    localparam int RAD_W         = 2 * SQ_STEPS;
    localparam int REM_W         = SQ_STEPS + 3;
    localparam int CW            = 34;
    localparam int ANG_W         = 21;
    localparam int NUM_W         = 46;
    localparam int DEN_W         = 42;
    localparam int PIPE_DEPTH    = 13 + 3 * SQ_STEPS + CORDIC_STAGES;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 15;

    localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_Y_ZERO = 2'd1;
    localparam logic [1:0] ST_A_ZERO = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    localparam int LN_HIP = 0;
    localparam int LN_AZ  = 1;
    localparam int LN_AC1 = 2;
    localparam int LN_AC2 = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIP_OFFSET = 3'd0,
        REG_UPPER_LINK = 3'd1,
        REG_LOWER_LINK = 3'd2,
        REG_RIGHT_LEG  = 3'd3,
        REG_OFFSET_X   = 3'd4,
        REG_OFFSET_Y   = 3'd5,
        REG_OFFSET_Z   = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
    } target_t;

    typedef struct packed {
        logic signed [15:0] hip_command;
        logic signed [15:0] mid_command;
        logic signed [15:0] low_command;
        logic [1:0]         status;
    } joint_t;

    typedef struct packed {
        logic signed [21:0]              hip_x;
        logic signed [21:0]              hip_y;
        logic                            y_zero;
        logic                            x_neg;
        logic signed [21:0]              z16;
        logic                            z_neg;
        logic signed [22:0]              a;
        logic                            a_zero;
        logic [43:0]                     c2;
        logic [1:0][SQ_STEPS-1:0]        mag;
        logic [1:0]                      neg;
        logic [1:0]                      zd;
        logic                            sat;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [REM_W-1:0]    rem;
        logic [SQ_STEPS-1:0] root;
    } sq_lane_t;

    typedef struct packed {
        sq_lane_t [1:0] lane;
        side_t          side;
    } sq_t;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ANG_W-1:0] ang;
    } cd_lane_t;

    typedef struct packed {
        cd_lane_t [3:0] lane;
        side_t          side;
    } cd_t;

    // atan(2^-i) in q16 radians
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STAGE_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            5'd0:    v = ANG_W'(51472);
            5'd1:    v = ANG_W'(30386);
            5'd2:    v = ANG_W'(16055);
            5'd3:    v = ANG_W'(8150);
            5'd4:    v = ANG_W'(4091);
            5'd5:    v = ANG_W'(2047);
            5'd6:    v = ANG_W'(1024);
            5'd7:    v = ANG_W'(512);
            5'd8:    v = ANG_W'(256);
            5'd9:    v = ANG_W'(128);
            5'd10:   v = ANG_W'(64);
            5'd11:   v = ANG_W'(32);
            5'd12:   v = ANG_W'(16);
            5'd13:   v = ANG_W'(8);
            5'd14:   v = ANG_W'(4);
            5'd15:   v = ANG_W'(2);
            5'd16:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // q16 angle to q4.12, round half up
    function automatic logic [15:0] to_q12(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] t;
        t = (v + ANG_W'(8)) >>> 4;
        return t[15:0];
    endfunction

endpackage

// ===== rtl/leg_inverse_kinematics_3dof.sv =====
// leg_inverse_kinematics_3dof: three joint inverse kinematics for one leg, fully pipelined
// depends on lik_pkg, lik_sqrt_cell, lik_cordic_cell
//
// usage
//   target channel: target_valid / target_stall / target carries a foot position x, y, z
//   in 1/16 mm. a transfer happens at a clock edge with valid high and stall low.
//   joint channel: joint_valid / joint_stall / joint returns hip, mid and low angles in
//   q4.12 radians plus a status code, one result per target, in order.
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data writes one register per
//   transfer; cfg_ready is always high. write only while no target is in flight.
// timing
//   one target per cycle sustained while the output is not stalled; the pipeline has
//   three square root chains of 30 digit cells each, a 16 stage cordic row with four
//   lanes, and 13 arithmetic and output registers.
// reset
//   rst_n clears all valid flags and loads the default link lengths and offsets.
// backpressure
//   the last pipeline register is the output register; while it holds a result and
//   joint_stall is high, the whole pipeline holds and target_stall is raised.
module leg_inverse_kinematics_3dof (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               target_valid,
    output logic                               target_stall,
    input  lik_pkg::target_t                   target,
    output logic                               joint_valid,
    input  logic                               joint_stall,
    output lik_pkg::joint_t                    joint,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lik_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [14:0]        hip_len_reg;
    logic [14:0]        upper_len_reg;
    logic [14:0]        lower_len_reg;
    logic               right_leg_reg;
    logic signed [12:0] ofs_x_reg;
    logic signed [12:0] ofs_y_reg;
    logic signed [12:0] ofs_z_reg;

    // control
    logic [lik_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [lik_pkg::PIPE_DEPTH-1:0] vld_next;
    logic                           en;

    // payload stages
    logic signed [16:0] x_reg, y_reg, z_reg;
    logic signed [16:0] x_next, y_next, z_next;
    logic [31:0]        xx_reg, yy_reg, xx_next, yy_next;
    lik_pkg::side_t     side1_reg, side1_next;
    lik_pkg::sq_t       sqa_reg, sqa_next;
    lik_pkg::sq_t       sqa [lik_pkg::SQ_STEPS+1];
    lik_pkg::side_t     side3_reg, side3_next;
    logic [29:0]        rho;
    logic [43:0]        aa_reg, zz_reg, aa_next, zz_next;
    lik_pkg::side_t     side4_reg;
    lik_pkg::sq_t       sqb_reg, sqb_next;
    lik_pkg::sq_t       sqb [lik_pkg::SQ_STEPS+1];
    logic [18:0]        m4, l4;
    logic [21:0]        c_len;
    logic [37:0]        mm_reg, ll_reg, ml_reg, mm_next, ll_next, ml_next;
    logic [40:0]        cm_reg, cm_next;
    lik_pkg::side_t     side6_reg;
    logic signed [lik_pkg::NUM_W-1:0] t_num_reg [2];
    logic signed [lik_pkg::NUM_W-1:0] t_num_next [2];
    logic [lik_pkg::DEN_W-1:0]        t_den_reg [2];
    logic [lik_pkg::DEN_W-1:0]        t_den_next [2];
    lik_pkg::side_t     side7_reg;
    logic [lik_pkg::NUM_W-1:0]        abs_num [2];
    logic [lik_pkg::DEN_W-1:0]        mag_reg [2];
    logic [lik_pkg::DEN_W-1:0]        mag_next [2];
    logic [lik_pkg::DEN_W-1:0]        den_reg [2];
    lik_pkg::side_t     side8_reg, side8_next;
    logic [3:0]         shamt [2];
    logic [lik_pkg::DEN_W-1:0]        den_sh [2];
    logic [lik_pkg::DEN_W-1:0]        mag_sh [2];
    logic [lik_pkg::SQ_STEPS-1:0]     ds_reg [2];
    logic [lik_pkg::SQ_STEPS-1:0]     ds_next [2];
    lik_pkg::side_t     side9_reg, side9_next;
    logic [lik_pkg::RAD_W-1:0]        dd_reg [2];
    logic [lik_pkg::RAD_W-1:0]        mm2_reg [2];
    logic [lik_pkg::RAD_W-1:0]        dd_next [2];
    logic [lik_pkg::RAD_W-1:0]        mm2_next [2];
    lik_pkg::side_t     side10_reg;
    lik_pkg::sq_t       sqc_reg, sqc_next;
    lik_pkg::sq_t       sqc [lik_pkg::SQ_STEPS+1];
    lik_pkg::cd_t       cd_in;
    lik_pkg::cd_t       cd [lik_pkg::CORDIC_STAGES+1];

    // result
    logic signed [lik_pkg::ANG_W-1:0] ah, ah_leg, az, am, lo;
    logic signed [lik_pkg::ANG_W-1:0] ac [2];
    logic [1:0]         st;
    lik_pkg::joint_t    joint_reg, joint_next;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hip_len_reg   <= 15'd480;
            upper_len_reg <= 15'd1600;
            lower_len_reg <= 15'd1600;
            right_leg_reg <= 1'b0;
            ofs_x_reg     <= '0;
            ofs_y_reg     <= '0;
            ofs_z_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (lik_pkg::cfg_reg_e'(cfg_index))
                lik_pkg::REG_HIP_OFFSET: hip_len_reg   <= cfg_data;
                lik_pkg::REG_UPPER_LINK: upper_len_reg <= cfg_data;
                lik_pkg::REG_LOWER_LINK: lower_len_reg <= cfg_data;
                lik_pkg::REG_RIGHT_LEG:  right_leg_reg <= cfg_data[0];
                lik_pkg::REG_OFFSET_X:   ofs_x_reg     <= cfg_data[12:0];
                lik_pkg::REG_OFFSET_Y:   ofs_y_reg     <= cfg_data[12:0];
                lik_pkg::REG_OFFSET_Z:   ofs_z_reg     <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    assign en           = !vld_reg[lik_pkg::PIPE_DEPTH-1] || !joint_stall;
    assign target_stall = !en;
    assign vld_next     = {vld_reg[lik_pkg::PIPE_DEPTH-2:0], target_valid};
    assign joint_valid  = vld_reg[lik_pkg::PIPE_DEPTH-1];
    assign joint        = joint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // compensation, squares, hip vector
    always_comb
    begin
        x_next  = 17'(target.target_x) + 17'(ofs_x_reg);
        y_next  = 17'(target.target_y) + 17'(ofs_y_reg);
        z_next  = 17'(target.target_z) + 17'(ofs_z_reg);
        xx_next = 32'(x_reg * x_reg);
        yy_next = 32'(y_reg * y_reg);

        side1_next        = '0;
        side1_next.hip_x  = y_reg[16] ? -(22'(y_reg) <<< 4) : (22'(y_reg) <<< 4);
        side1_next.hip_y  = y_reg[16] ? -(22'(x_reg) <<< 4) : (22'(x_reg) <<< 4);
        side1_next.y_zero = (y_reg == '0);
        side1_next.x_neg  = x_reg[16];
        side1_next.z16    = 22'(z_reg) <<< 4;
        side1_next.z_neg  = z_reg[16];

        sqa_next              = '0;
        sqa_next.lane[0].rad  = lik_pkg::RAD_W'({(33'(xx_reg) + 33'(yy_reg)), 8'd0});
        sqa_next.side         = side1_reg;
    end

    assign sqa[0] = sqa_reg;

    for (genvar i = 0; i < lik_pkg::SQ_STEPS; i++)
    begin : g_sqa
        lik_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (sqa[i]),
            .q   (sqa[i+1])
        );
    end

    // radial offset and squared reach
    always_comb
    begin
        rho               = sqa[lik_pkg::SQ_STEPS].lane[0].root;
        side3_next        = sqa[lik_pkg::SQ_STEPS].side;
        side3_next.a      = $signed(23'(rho)) - $signed(23'({hip_len_reg, 4'd0}));
        side3_next.a_zero = (side3_next.a == '0);
        aa_next           = 44'(side3_reg.a * side3_reg.a);
        zz_next           = 44'(side3_reg.z16 * side3_reg.z16);

        sqb_next             = '0;
        sqb_next.side        = side4_reg;
        sqb_next.side.c2     = aa_reg + zz_reg;
        sqb_next.lane[0].rad = lik_pkg::RAD_W'(aa_reg + zz_reg);
    end

    assign sqb[0] = sqb_reg;

    for (genvar i = 0; i < lik_pkg::SQ_STEPS; i++)
    begin : g_sqb
        lik_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (sqb[i]),
            .q   (sqb[i+1])
        );
    end

    // law of cosines terms
    always_comb
    begin
        m4      = {upper_len_reg, 4'd0};
        l4      = {lower_len_reg, 4'd0};
        c_len   = sqb[lik_pkg::SQ_STEPS].lane[0].root[21:0];
        mm_next = 38'(m4) * 38'(m4);
        ll_next = 38'(l4) * 38'(l4);
        ml_next = 38'(m4) * 38'(l4);
        cm_next = 41'(c_len) * 41'(m4);

        t_num_next[0] = $signed(lik_pkg::NUM_W'(side6_reg.c2)) + $signed(lik_pkg::NUM_W'(mm_reg))
                      - $signed(lik_pkg::NUM_W'(ll_reg));
        t_num_next[1] = $signed(lik_pkg::NUM_W'(ll_reg)) + $signed(lik_pkg::NUM_W'(mm_reg))
                      - $signed(lik_pkg::NUM_W'(side6_reg.c2));
        t_den_next[0] = lik_pkg::DEN_W'({cm_reg, 1'b0});
        t_den_next[1] = lik_pkg::DEN_W'({ml_reg, 1'b0});

        // clamp to the unit range
        side8_next = side7_reg;
        for (int k = 0; k < 2; k++)
        begin
            side8_next.neg[k] = t_num_reg[k][lik_pkg::NUM_W-1];
            side8_next.zd[k]  = (t_den_reg[k] == '0);
            abs_num[k]        = t_num_reg[k][lik_pkg::NUM_W-1] ? lik_pkg::NUM_W'(-t_num_reg[k])
                                                               : lik_pkg::NUM_W'(t_num_reg[k]);
            if (abs_num[k] > lik_pkg::NUM_W'(t_den_reg[k]))
            begin
                mag_next[k] = t_den_reg[k];
            end
            else
            begin
                mag_next[k] = abs_num[k][lik_pkg::DEN_W-1:0];
            end
        end
        side8_next.sat = side7_reg.sat
                       || (abs_num[0] > lik_pkg::NUM_W'(t_den_reg[0])) || (t_den_reg[0] == '0)
                       || (abs_num[1] > lik_pkg::NUM_W'(t_den_reg[1])) || (t_den_reg[1] == '0);

        // scale the denominator below 2^30
        side9_next = side8_reg;
        for (int k = 0; k < 2; k++)
        begin
            shamt[k] = '0;
            for (int b = lik_pkg::SQ_STEPS; b < lik_pkg::DEN_W; b++)
            begin
                if (den_reg[k][b])
                begin
                    shamt[k] = 4'(b - lik_pkg::SQ_STEPS + 1);
                end
            end
            den_sh[k]          = den_reg[k] >> shamt[k];
            mag_sh[k]          = mag_reg[k] >> shamt[k];
            ds_next[k]         = den_sh[k][lik_pkg::SQ_STEPS-1:0];
            side9_next.mag[k]  = mag_sh[k][lik_pkg::SQ_STEPS-1:0];
            dd_next[k]         = lik_pkg::RAD_W'(ds_reg[k]) * lik_pkg::RAD_W'(ds_reg[k]);
            mm2_next[k]        = lik_pkg::RAD_W'(side9_reg.mag[k])
                               * lik_pkg::RAD_W'(side9_reg.mag[k]);
        end

        sqc_next      = '0;
        sqc_next.side = side10_reg;
        for (int k = 0; k < 2; k++)
        begin
            sqc_next.lane[k].rad = dd_reg[k] - mm2_reg[k];
        end
    end

    assign sqc[0] = sqc_reg;

    for (genvar i = 0; i < lik_pkg::SQ_STEPS; i++)
    begin : g_sqc
        lik_sqrt_cell u_cell (
            .clk (clk),
            .en  (en),
            .d   (sqc[i]),
            .q   (sqc[i+1])
        );
    end

    // cordic entry vectors
    always_comb
    begin
        cd_in      = '0;
        cd_in.side = sqc[lik_pkg::SQ_STEPS].side;
        cd_in.lane[lik_pkg::LN_HIP].x = lik_pkg::CW'(cd_in.side.hip_x);
        cd_in.lane[lik_pkg::LN_HIP].y = lik_pkg::CW'(cd_in.side.hip_y);
        if (!cd_in.side.a[22])
        begin
            cd_in.lane[lik_pkg::LN_AZ].x = lik_pkg::CW'(cd_in.side.a);
            cd_in.lane[lik_pkg::LN_AZ].y = lik_pkg::CW'(cd_in.side.z16);
        end
        else
        begin
            cd_in.lane[lik_pkg::LN_AZ].x = lik_pkg::CW'(-cd_in.side.a);
            cd_in.lane[lik_pkg::LN_AZ].y = lik_pkg::CW'(-cd_in.side.z16);
        end
        for (int k = 0; k < 2; k++)
        begin
            if (cd_in.side.neg[k])
            begin
                cd_in.lane[lik_pkg::LN_AC1+k].x = lik_pkg::CW'(sqc[lik_pkg::SQ_STEPS].lane[k].root);
                cd_in.lane[lik_pkg::LN_AC1+k].y = lik_pkg::CW'(cd_in.side.mag[k]);
            end
            else
            begin
                cd_in.lane[lik_pkg::LN_AC1+k].x = lik_pkg::CW'(cd_in.side.mag[k]);
                cd_in.lane[lik_pkg::LN_AC1+k].y = lik_pkg::CW'(sqc[lik_pkg::SQ_STEPS].lane[k].root);
            end
        end
    end

    assign cd[0] = cd_in;

    for (genvar i = 0; i < lik_pkg::CORDIC_STAGES; i++)
    begin : g_cd
        lik_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .stage (lik_pkg::STAGE_W'(i)),
            .d     (cd[i]),
            .q     (cd[i+1])
        );
    end

    // joint angles and status
    always_comb
    begin
        if (cd[lik_pkg::CORDIC_STAGES].side.y_zero)
        begin
            ah = cd[lik_pkg::CORDIC_STAGES].side.x_neg ? -lik_pkg::HALF_PI_Q16
                                                       : lik_pkg::HALF_PI_Q16;
        end
        else
        begin
            ah = cd[lik_pkg::CORDIC_STAGES].lane[lik_pkg::LN_HIP].ang;
        end
        ah_leg = right_leg_reg ? ah : -ah;

        if (cd[lik_pkg::CORDIC_STAGES].side.a_zero)
        begin
            az = cd[lik_pkg::CORDIC_STAGES].side.z_neg ? -lik_pkg::HALF_PI_Q16
                                                       : lik_pkg::HALF_PI_Q16;
        end
        else
        begin
            az = cd[lik_pkg::CORDIC_STAGES].lane[lik_pkg::LN_AZ].ang;
        end

        for (int k = 0; k < 2; k++)
        begin
            if (cd[lik_pkg::CORDIC_STAGES].side.zd[k])
            begin
                ac[k] = cd[lik_pkg::CORDIC_STAGES].side.neg[k] ? lik_pkg::PI_Q16 : '0;
            end
            else if (cd[lik_pkg::CORDIC_STAGES].side.neg[k])
            begin
                ac[k] = lik_pkg::HALF_PI_Q16 + cd[lik_pkg::CORDIC_STAGES].lane[lik_pkg::LN_AC1+k].ang;
            end
            else
            begin
                ac[k] = cd[lik_pkg::CORDIC_STAGES].lane[lik_pkg::LN_AC1+k].ang;
            end
        end
        am = az - ac[0];
        lo = lik_pkg::HALF_PI_Q16 - ac[1];

        priority if (cd[lik_pkg::CORDIC_STAGES].side.sat)
        begin
            st = lik_pkg::ST_SAT;
        end
        else if (cd[lik_pkg::CORDIC_STAGES].side.a_zero)
        begin
            st = lik_pkg::ST_A_ZERO;
        end
        else if (cd[lik_pkg::CORDIC_STAGES].side.y_zero)
        begin
            st = lik_pkg::ST_Y_ZERO;
        end
        else
        begin
            st = lik_pkg::ST_OK;
        end

        joint_next.hip_command = lik_pkg::to_q12(-ah_leg);
        joint_next.mid_command = lik_pkg::to_q12(am);
        joint_next.low_command = lik_pkg::to_q12(lo);
        joint_next.status      = st;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            xx_reg     <= xx_next;
            yy_reg     <= yy_next;
            side1_reg  <= side1_next;
            sqa_reg    <= sqa_next;
            side3_reg  <= side3_next;
            aa_reg     <= aa_next;
            zz_reg     <= zz_next;
            side4_reg  <= side3_reg;
            sqb_reg    <= sqb_next;
            mm_reg     <= mm_next;
            ll_reg     <= ll_next;
            ml_reg     <= ml_next;
            cm_reg     <= cm_next;
            side6_reg  <= sqb[lik_pkg::SQ_STEPS].side;
            t_num_reg  <= t_num_next;
            t_den_reg  <= t_den_next;
            side7_reg  <= side6_reg;
            mag_reg    <= mag_next;
            den_reg    <= t_den_reg;
            side8_reg  <= side8_next;
            ds_reg     <= ds_next;
            side9_reg  <= side9_next;
            dd_reg     <= dd_next;
            mm2_reg    <= mm2_next;
            side10_reg <= side9_reg;
            sqc_reg    <= sqc_next;
            joint_reg  <= joint_next;
        end
    end

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (joint_valid && joint_stall) |=> joint_valid)
        else $error("result dropped while stalled");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while held");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (target_valid && !target_stall) |=> vld_reg[0])
        else $error("accepted target not entered");

endmodule

// ===== rtl/lik_sqrt_cell.sv =====
// lik_sqrt_cell: one digit step of a two-lane integer square root chain
// carries the side data of its item along; depends on lik_pkg
module lik_sqrt_cell (
    input  logic         clk,
    input  logic         en,
    input  lik_pkg::sq_t d,
    output lik_pkg::sq_t q
);

    lik_pkg::sq_t               q_reg;
    lik_pkg::sq_t               q_next;
    logic [lik_pkg::REM_W-1:0]  cur   [2];
    logic [lik_pkg::REM_W-1:0]  trial [2];

    always_comb
    begin
        q_next = d;
        for (int k = 0; k < 2; k++)
        begin
            cur[k]   = {d.lane[k].rem[lik_pkg::REM_W-3:0], d.lane[k].rad[lik_pkg::RAD_W-1 -: 2]};
            trial[k] = {1'b0, d.lane[k].root, 2'b01};
            q_next.lane[k].rad = {d.lane[k].rad[lik_pkg::RAD_W-3:0], 2'b00};
            if (cur[k] >= trial[k])
            begin
                q_next.lane[k].rem  = cur[k] - trial[k];
                q_next.lane[k].root = {d.lane[k].root[lik_pkg::SQ_STEPS-2:0], 1'b1};
            end
            else
            begin
                q_next.lane[k].rem  = cur[k];
                q_next.lane[k].root = {d.lane[k].root[lik_pkg::SQ_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/lik_cordic_cell.sv =====
// lik_cordic_cell: one vectoring step of four parallel cordic lanes
// carries the side data of its item along; depends on lik_pkg
module lik_cordic_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lik_pkg::STAGE_W-1:0]   stage,
    input  lik_pkg::cd_t                  d,
    output lik_pkg::cd_t                  q
);

    lik_pkg::cd_t                    q_reg;
    lik_pkg::cd_t                    q_next;
    logic signed [lik_pkg::CW-1:0]   dx [4];
    logic signed [lik_pkg::CW-1:0]   dy [4];
    logic signed [lik_pkg::ANG_W-1:0] step_ang;

    always_comb
    begin
        q_next   = d;
        step_ang = lik_pkg::atan_q16(stage);
        for (int k = 0; k < 4; k++)
        begin
            dx[k] = d.lane[k].y >>> stage;
            dy[k] = d.lane[k].x >>> stage;
            if (!d.lane[k].y[lik_pkg::CW-1] && (d.lane[k].y != '0))
            begin
                q_next.lane[k].x   = d.lane[k].x + dx[k];
                q_next.lane[k].y   = d.lane[k].y - dy[k];
                q_next.lane[k].ang = d.lane[k].ang + step_ang;
            end
            else if (d.lane[k].y[lik_pkg::CW-1])
            begin
                q_next.lane[k].x   = d.lane[k].x - dx[k];
                q_next.lane[k].y   = d.lane[k].y + dy[k];
                q_next.lane[k].ang = d.lane[k].ang - step_ang;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== tb/testbench.sv =====
// testbench: checks leg_inverse_kinematics_3dof against a bit-exact solver of its own
// uses lik_pkg for the port types and register indexes; drives targets with random gaps
// and stalls, writes every register between phases, and compares each joint transfer
`timescale 1ns / 1ps

module testbench;

    localparam int N_STAGES   = lik_pkg::CORDIC_STAGES;
    localparam longint PI_Q   = longint'(lik_pkg::PI_Q16);
    localparam longint HPI_Q  = longint'(lik_pkg::HALF_PI_Q16);
    localparam int DRAIN      = lik_pkg::PIPE_DEPTH + 40;

    logic             clk;
    logic             rst_n;
    logic             target_valid;
    logic             target_stall;
    lik_pkg::target_t target;
    logic             joint_valid;
    logic             joint_stall;
    lik_pkg::joint_t  joint;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [lik_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lik_pkg::CFG_DATA_W-1:0] cfg_data;
    logic             target_taken;

    leg_inverse_kinematics_3dof u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .target       (target),
        .joint_valid  (joint_valid),
        .joint_stall  (joint_stall),
        .joint        (joint),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    longint hip_len, upper_len, lower_len, right_leg, off_x, off_y, off_z;

    lik_pkg::target_t pending_targets[$];
    lik_pkg::joint_t  expected_joints[$];
    int      errors;
    int      n_results;
    int      burst_left;
    int      gap_left;
    int      stall_mode;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint shr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint atan_step(int i);
        longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? tab[i] : 0;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        for (int i = 0; i < N_STAGES; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                ang += atan_step(i);
            end
            else if (y < 0)
            begin
                x -= dx;
                y += dy;
                ang -= atan_step(i);
            end
        end
        return ang;
    endfunction

    function automatic longint arc_cos(longint num, longint den, ref bit clamped);
        longint unsigned mag;
        longint unsigned d;
        longint s;
        bit neg;
        neg = num < 0;
        if (den <= 0)
        begin
            clamped = 1'b1;
            return neg ? PI_Q : 0;
        end
        mag = neg ? longint'(-num) : num;
        d = den;
        if (mag > d)
        begin
            clamped = 1'b1;
            mag = d;
        end
        while (d >= (64'd1 << 30))
        begin
            d >>= 1;
            mag >>= 1;
        end
        s = int_sqrt(d * d - mag * mag);
        if (!neg)
            return vector_angle(mag, s);
        return HPI_Q + vector_angle(s, mag);
    endfunction

    function automatic logic [15:0] round_q12(longint v);
        longint t;
        t = shr(v + 8, 4);
        return t[15:0];
    endfunction

    function automatic lik_pkg::joint_t solve_leg(lik_pkg::target_t t);
        longint x, y, z, ah, az, a, c, c2, m4, l4, am, lo;
        bit clamped;
        logic [1:0] st;
        lik_pkg::joint_t j;
        x = longint'(t.target_x) + off_x;
        y = longint'(t.target_y) + off_y;
        z = longint'(t.target_z) + off_z;
        clamped = 1'b0;
        st = lik_pkg::ST_OK;
        if (y == 0)
        begin
            st = lik_pkg::ST_Y_ZERO;
            ah = (x >= 0) ? HPI_Q : -HPI_Q;
        end
        else
            ah = (y > 0) ? vector_angle(y * 16, x * 16) : vector_angle(-y * 16, -x * 16);
        if (right_leg == 0)
            ah = -ah;
        a = int_sqrt((x * x + y * y) << 8) - hip_len * 16;
        if (a == 0)
        begin
            st = lik_pkg::ST_A_ZERO;
            az = (z >= 0) ? HPI_Q : -HPI_Q;
        end
        else
            az = (a > 0) ? vector_angle(a, z * 16) : vector_angle(-a, -z * 16);
        c2 = a * a + z * z * 256;
        c = int_sqrt(c2);
        m4 = upper_len * 16;
        l4 = lower_len * 16;
        am = az - arc_cos(c2 + m4 * m4 - l4 * l4, 2 * c * m4, clamped);
        lo = HPI_Q - arc_cos(l4 * l4 + m4 * m4 - c2, 2 * m4 * l4, clamped);
        if (clamped)
            st = lik_pkg::ST_SAT;
        j.hip_command = round_q12(-ah);
        j.mid_command = round_q12(am);
        j.low_command = round_q12(lo);
        j.status = st;
        return j;
    endfunction

    // target transfers as seen at the rising edge
    always @(posedge clk)
    begin
        target_taken <= rst_n && target_valid && !target_stall;
        if (rst_n && target_valid && !target_stall)
            expected_joints.push_back(solve_leg(target));
    end

    // driver: bursts and gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!target_valid || target_taken)
            begin
                if (gap_left > 0 || pending_targets.size() == 0)
                begin
                    target_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    target_valid <= 1'b1;
                    target <= pending_targets.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            case (stall_mode)
                0: joint_stall <= 1'b0;
                1: joint_stall <= ($urandom_range(0, 3) == 0);
                default: joint_stall <= ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 99) == 0)
                stall_mode = $urandom_range(0, 2);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && joint_valid && !joint_stall)
        begin
            n_results++;
            if (expected_joints.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected joint transfer %h", $time, joint);
            end
            else
            begin
                lik_pkg::joint_t e;
                e = expected_joints.pop_front();
                if (joint.hip_command !== e.hip_command)
                    $display("%0t: hip expected %0d actual %0d", $time,
                             e.hip_command, joint.hip_command);
                if (joint.mid_command !== e.mid_command)
                    $display("%0t: mid expected %0d actual %0d", $time,
                             e.mid_command, joint.mid_command);
                if (joint.low_command !== e.low_command)
                    $display("%0t: low expected %0d actual %0d", $time,
                             e.low_command, joint.low_command);
                if (joint.status !== e.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, joint.status);
                if (joint !== e)
                    errors++;
            end
        end
    end

    task automatic write_reg(lik_pkg::cfg_reg_e idx, longint value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= lik_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            lik_pkg::REG_HIP_OFFSET: hip_len = value & 32'h7fff;
            lik_pkg::REG_UPPER_LINK: upper_len = value & 32'h7fff;
            lik_pkg::REG_LOWER_LINK: lower_len = value & 32'h7fff;
            lik_pkg::REG_RIGHT_LEG:  right_leg = value & 1;
            lik_pkg::REG_OFFSET_X:   off_x = longint'($signed(13'(value)));
            lik_pkg::REG_OFFSET_Y:   off_y = longint'($signed(13'(value)));
            default:                 off_z = longint'($signed(13'(value)));
        endcase
    endtask

    task automatic wait_idle();
        while (pending_targets.size() != 0 || target_valid || expected_joints.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic add_target(longint x, longint y, longint z);
        lik_pkg::target_t t;
        t.target_x = 16'(x);
        t.target_y = 16'(y);
        t.target_z = 16'(z);
        pending_targets.push_back(t);
    endtask

    task automatic add_reachable(int n);
        longint r, h, x, y;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_target($urandom, $urandom, $urandom);
            else
            begin
                // reachable-ish: radial distance near hip offset plus links
                r = hip_len + longint'($urandom_range(0, 32'(upper_len + lower_len + 1)));
                h = longint'($urandom_range(0, 32'(r)));
                x = longint'($urandom_range(0, 32'(2 * h))) - h;
                y = (r * r - x * x > 0) ? longint'($rtoi($sqrt(real'(r * r - x * x)))) : 0;
                if ($urandom_range(0, 1))
                    y = -y;
                add_target(x - off_x, y - off_y,
                           longint'($urandom_range(0, 32'(2 * lower_len))) - lower_len);
            end
        end
    endtask

    task automatic random_config();
        write_reg(lik_pkg::REG_HIP_OFFSET, $urandom_range(0, 3000));
        write_reg(lik_pkg::REG_UPPER_LINK, $urandom_range(1, 4000));
        write_reg(lik_pkg::REG_LOWER_LINK, $urandom_range(1, 4000));
        write_reg(lik_pkg::REG_RIGHT_LEG, $urandom_range(0, 1));
        write_reg(lik_pkg::REG_OFFSET_X, $urandom_range(0, 8191));
        write_reg(lik_pkg::REG_OFFSET_Y, $urandom_range(0, 8191));
        write_reg(lik_pkg::REG_OFFSET_Z, $urandom_range(0, 8191));
    endtask

    initial
    begin
        errors = 0;
        n_results = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 1;
        rst_n = 1'b0;
        target_valid = 1'b0;
        target = '0;
        joint_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lik_pkg::REG_HIP_OFFSET;
        cfg_data = '0;
        hip_len = 480;
        upper_len = 1600;
        lower_len = 1600;
        right_leg = 0;
        off_x = 0;
        off_y = 0;
        off_z = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes and special cases at reset settings
        add_target(0, 0, 0);
        add_target(32767, 32767, 32767);
        add_target(-32768, -32768, -32768);
        add_target(100, 0, 50);
        add_target(-100, 0, -50);
        add_target(0, 480, 0);
        add_target(0, 480, -10);
        add_target(0, 3000, -1000);
        add_target(0, -3000, 1000);
        add_target(32767, -32768, 0);
        add_target(-1, 1, -1);
        add_target(1000, 2000, -1500);
        wait_idle();

        // extremes of the registers
        write_reg(lik_pkg::REG_HIP_OFFSET, 32767);
        write_reg(lik_pkg::REG_UPPER_LINK, 32767);
        write_reg(lik_pkg::REG_LOWER_LINK, 32767);
        write_reg(lik_pkg::REG_RIGHT_LEG, 1);
        write_reg(lik_pkg::REG_OFFSET_X, 4095);
        write_reg(lik_pkg::REG_OFFSET_Y, -4096);
        write_reg(lik_pkg::REG_OFFSET_Z, 4095);
        add_target(-32768, 32767, -32768);
        add_target(32767, -32768, 32767);
        add_target(0, 4096, 0);
        add_target(-4095, 4096, -4095);
        add_reachable(40);
        wait_idle();

        write_reg(lik_pkg::REG_HIP_OFFSET, 0);
        write_reg(lik_pkg::REG_UPPER_LINK, 1);
        write_reg(lik_pkg::REG_LOWER_LINK, 1);
        write_reg(lik_pkg::REG_RIGHT_LEG, 0);
        write_reg(lik_pkg::REG_OFFSET_X, -4096);
        write_reg(lik_pkg::REG_OFFSET_Y, 4095);
        write_reg(lik_pkg::REG_OFFSET_Z, -4096);
        add_target(4096, -4095, 4096);
        add_target(4096, -4095, 4097);
        add_reachable(40);
        wait_idle();

        for (int p = 0; p < 7; p++)
        begin
            random_config();
            add_reachable(200);
            wait_idle();
        end

        $display("run covered %0d joint transfers over 10 register settings", n_results);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
